// ===== hw/rtl/gda_pkg.sv =====
// ----------------------------------------------------------------------------
// gda_pkg
// Shared types, codes and constants of the geofence distance alarm.
// ----------------------------------------------------------------------------
package gda_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 24;
  localparam int QUEUE_DEPTH           = 4;
  localparam int CW                    = 34;   // cordic datapath width
  localparam int SQRT_STEPS            = 31;   // result bits of the root

  localparam logic signed [26:0] QUARTER_TURN = 27'sd11796480;  // 90 deg, 2^-17 units
  localparam logic signed [26:0] HALF_TURN    = 27'sd23592960;
  localparam logic signed [31:0] DEG_TO_RAD   = 32'sd74961321;
  localparam logic signed [CW-1:0] GAIN_INV   = 34'sd652032874;
  localparam logic signed [31:0] TWO_EARTH_KM = 32'sd12742;
  localparam logic [30:0]        ONE_Q30      = 31'h4000_0000;
  localparam logic [22:0]        DIST_MAX     = 23'd5123840;
  localparam logic [15:0]        DURATION_RST = 16'd15000;

  localparam logic [1:0] REG_HOME_LAT = 2'd0;
  localparam logic [1:0] REG_HOME_LON = 2'd1;
  localparam logic [1:0] REG_DURATION = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK, OP_ALARM_ON, OP_ALARM_OFF, OP_RESET
  } opcode_t;

  typedef enum logic [2:0] {
    ST_NONE, ST_STARTED, ST_OUTSIDE, ST_UNSET, ST_OFF, ST_TIMEOUT
  } status_t;

  typedef enum logic [2:0] {
    KIND_TICK, KIND_GEO, KIND_UNSET, KIND_OFF, KIND_CLEAR
  } kind_t;

  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_ANGLE, SEQ_ZLOAD, SEQ_ROT, SEQ_MUL1, SEQ_MUL2, SEQ_MUL3,
    SEQ_MUL4, SEQ_MUL5, SEQ_ASUM, SEQ_SQRT, SEQ_VLOAD, SEQ_VEC, SEQ_DMUL,
    SEQ_DIST, SEQ_RESULT
  } seq_state_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [23:0] lat;
    logic signed [24:0] lon;
    logic [22:0]        radius;
  } item_t;

  typedef struct packed {
    logic                 start;
    logic                 vec;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_rsp_t;

  // arctangent of 2^-i in radians, Q30
  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'h3243F6A8 & 30'h3FFFFFFF;
      5'd1:  v = 30'h1DAC6705;
      5'd2:  v = 30'h0FADBAFC;
      5'd3:  v = 30'h07F56EA6;
      5'd4:  v = 30'h03FEAB76;
      5'd5:  v = 30'h01FFD55B;
      5'd6:  v = 30'h00FFFAAA;
      5'd7:  v = 30'h007FFF55;
      5'd8:  v = 30'h003FFFEA;
      5'd9:  v = 30'h001FFFFD;
      5'd10: v = 30'h000FFFFF;
      5'd11: v = 30'h0007FFFF;
      5'd12: v = 30'h0003FFFF;
      5'd13: v = 30'h0001FFFF;
      5'd14: v = 30'h0000FFFF;
      5'd15: v = 30'h00007FFF;
      5'd16: v = 30'h00003FFF;
      5'd17: v = 30'h00001FFF;
      5'd18: v = 30'h00000FFF;
      5'd19: v = 30'h000007FF;
      5'd20: v = 30'h000003FF;
      5'd21: v = 30'h000001FF;
      5'd22: v = 30'h000000FF;
      5'd23: v = 30'h0000007F;
      5'd24: v = 30'h0000003F;
      5'd25: v = 30'h0000001F;
      5'd26: v = 30'h0000000F;
      5'd27: v = 30'h00000008;
      5'd28: v = 30'h00000004;
      5'd29: v = 30'h00000002;
      5'd30: v = 30'h00000001;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/gda_front.sv =====
// ----------------------------------------------------------------------------
// gda_front
// Input side: takes items, sorts them into kinds and queues them.
// ----------------------------------------------------------------------------
module gda_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [71:0]          in_tdata,   // quake_latitude, quake_longitude, danger_radius
  input  logic [1:0]           in_tuser,   // opcode
  input  logic signed [23:0]   home_lat,
  input  logic signed [24:0]   home_lon,
  output logic                 q_valid,
  output gda_pkg::item_t       q_item,
  input  logic                 q_pop
);
  import gda_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  item_t         mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;
  item_t         item_in;
  logic          push;

  always_comb begin
    item_in.lat    = signed'(in_tdata[23:0]);
    item_in.lon    = signed'(in_tdata[48:24]);
    item_in.radius = in_tdata[71:49];
    unique case (opcode_t'(in_tuser))
      OP_TICK:      item_in.kind = KIND_TICK;
      OP_ALARM_ON: begin
        // a home of exactly 0,0 means the position was never set
        item_in.kind = (home_lat == '0 && home_lon == '0) ? KIND_UNSET : KIND_GEO;
      end
      OP_ALARM_OFF: item_in.kind = KIND_OFF;
      OP_RESET:     item_in.kind = KIND_CLEAR;
      default:      item_in.kind = KIND_TICK;
    endcase
  end

  assign in_tready = (count_r != (PW+1)'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != '0);
  assign q_item    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (PW+1)'(push) - (PW+1)'(q_pop);
    end
  end

endmodule

// ===== hw/rtl/gda_cordic.sv =====
// ----------------------------------------------------------------------------
// gda_cordic
// Shared iterative CORDIC, one micro-rotation per cycle, rotation or vectoring.
// ----------------------------------------------------------------------------
module gda_cordic #(
  parameter int ITERATIONS = gda_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gda_pkg::cordic_req_t req,
  output gda_pkg::cordic_rsp_t rsp
);
  import gda_pkg::*;

  localparam int IW = $clog2(ITERATIONS);

  logic signed [CW-1:0] x_r, y_r, z_r;
  logic signed [CW-1:0] xs, ys, at, x_nxt, y_nxt, z_nxt;
  logic [IW-1:0]        i_r;
  logic                 vec_r, busy_r, done_r, dir;

  always_comb begin
    // dir set: x -= y>>i, y += x>>i, z -= atan
    dir   = vec_r ? (y_r[CW-1] || y_r == '0) : !z_r[CW-1];
    xs    = x_r >>> i_r;
    ys    = y_r >>> i_r;
    at    = signed'({{(CW-30){1'b0}}, atan_q30(5'(i_r))});
    x_nxt = dir ? x_r - ys : x_r + ys;
    y_nxt = dir ? y_r + xs : y_r - xs;
    z_nxt = dir ? z_r - at : z_r + at;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && i_r == IW'(ITERATIONS-1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r   <= req.x;
      y_r   <= req.y;
      z_r   <= req.z;
      vec_r <= req.vec;
      i_r   <= '0;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      i_r <= i_r + 1'b1;
    end
  end

  assign rsp = '{done: done_r, x: x_r, y: y_r, z: z_r};

endmodule

// ===== hw/rtl/gda_back.sv =====
// ----------------------------------------------------------------------------
// gda_back
// Execution side: haversine sequencer, shared multiplier, square roots,
// relay state and the output register.
// ----------------------------------------------------------------------------
module gda_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  gda_pkg::item_t       q_item,
  output logic                 q_pop,
  input  logic signed [23:0]   home_lat,
  input  logic signed [24:0]   home_lon,
  input  logic [15:0]          duration,
  output gda_pkg::cordic_req_t cordic_req,
  input  gda_pkg::cordic_rsp_t cordic_rsp,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // relay_on, distance
  output logic [2:0]           out_tuser   // status
);
  import gda_pkg::*;

  typedef struct packed {
    logic [61:0] v;
    logic [31:0] rem;
    logic [30:0] root;
  } sq_lane_t;

  // one two-bit step of the digit-by-digit floor square root
  function automatic sq_lane_t sq_step(input sq_lane_t l);
    logic [33:0] pre, trial;
    sq_lane_t    n;
    pre   = {l.rem, l.v[61:60]};
    trial = {1'b0, l.root, 2'b01};
    n.v   = {l.v[59:0], 2'b00};
    if (pre >= trial) begin
      n.rem  = 32'(pre - trial);
      n.root = {l.root[29:0], 1'b1};
    end else begin
      n.rem  = 32'(pre);
      n.root = {l.root[29:0], 1'b0};
    end
    return n;
  endfunction

  seq_state_t         state_r, state_nxt;
  item_t              item_r;
  logic [1:0]         k_r;
  logic               flip_r, neg_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] mul_a, mul_b;
  logic signed [31:0] s_dlat_r, s_dlon_r, c1_r, c2_r, t1_r, cc_r, sd_r, zc_r;
  sq_lane_t           p_lane_r, q_lane_r;
  logic [4:0]         sq_cnt_r;
  logic [22:0]        dist_r;

  logic               active_r, active_nxt;
  logic [15:0]        ticks_r, ticks_nxt, tick_inc;
  status_t            status_nxt;
  logic [22:0]        dist_out;

  logic               out_valid_r, out_relay_r;
  logic [22:0]        out_dist_r;
  logic [2:0]         out_status_r;
  logic               commit;

  logic signed [26:0] ang, ang_f;
  logic               ang_flip;
  logic [23:0]        ang_mag;
  logic [31:0]        zmag;
  logic signed [CW-1:0] z0;
  logic signed [31:0] rot_sin, rot_cos;
  logic signed [33:0] a_sum;
  logic [30:0]        a_c;
  logic signed [63:0] dround;
  logic [41:0]        dwide;

  // angle for the current CORDIC pass, 2^-17 degree units (half a difference or a whole latitude)
  always_comb begin
    unique case (k_r)
      2'd0:    ang = 27'(item_r.lat) - 27'(home_lat);
      2'd1:    ang = 27'(item_r.lon) - 27'(home_lon);
      2'd2:    ang = 27'(home_lat) <<< 1;
      default: ang = 27'(item_r.lat) <<< 1;
    endcase
    ang_flip = 1'b1;
    if (ang > QUARTER_TURN) begin
      ang_f = ang - HALF_TURN;
    end else if (ang < -QUARTER_TURN) begin
      ang_f = ang + HALF_TURN;
    end else begin
      ang_f    = ang;
      ang_flip = 1'b0;
    end
    ang_mag = 24'(ang_f[26] ? -ang_f : ang_f);
  end

  always_comb begin
    zmag    = 32'(prod_r >>> 19);
    z0      = neg_r ? -signed'({2'b00, zmag}) : signed'({2'b00, zmag});
    rot_sin = 32'(flip_r ? -cordic_rsp.y : cordic_rsp.y);
    rot_cos = 32'(flip_r ? -cordic_rsp.x : cordic_rsp.x);
    a_sum   = 34'(t1_r) + 34'(signed'(32'(prod_r >>> 30)));
    if (a_sum[33]) begin
      a_c = '0;
    end else if (a_sum > 34'(ONE_Q30)) begin
      a_c = ONE_Q30;
    end else begin
      a_c = 31'(a_sum);
    end
    dround = (prod_r + 64'sd2097152) >>> 22;
    dwide  = 42'(dround);
  end

  // result of the item, applied on commit
  always_comb begin
    tick_inc   = (ticks_r == 16'hFFFF) ? ticks_r : ticks_r + 1'b1;
    active_nxt = active_r;
    ticks_nxt  = ticks_r;
    status_nxt = ST_NONE;
    dist_out   = '0;
    unique case (item_r.kind)
      KIND_TICK: begin
        ticks_nxt = tick_inc;
        if (active_r && tick_inc >= duration) begin
          active_nxt = 1'b0;
          status_nxt = ST_TIMEOUT;
        end
      end
      KIND_GEO: begin
        dist_out = dist_r;
        if (dist_r <= item_r.radius) begin
          active_nxt = 1'b1;
          ticks_nxt  = '0;
          status_nxt = ST_STARTED;
        end else begin
          status_nxt = ST_OUTSIDE;
        end
      end
      KIND_UNSET: status_nxt = ST_UNSET;
      KIND_OFF: begin
        active_nxt = 1'b0;
        status_nxt = ST_OFF;
      end
      KIND_CLEAR: begin
        active_nxt = 1'b0;
        ticks_nxt  = '0;
      end
      default: status_nxt = ST_NONE;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEQ_IDLE:   if (q_valid) state_nxt = (q_item.kind == KIND_GEO) ? SEQ_ANGLE : SEQ_RESULT;
      SEQ_ANGLE:  state_nxt = SEQ_ZLOAD;
      SEQ_ZLOAD:  state_nxt = SEQ_ROT;
      SEQ_ROT:    if (cordic_rsp.done) state_nxt = (k_r == 2'd3) ? SEQ_MUL1 : SEQ_ANGLE;
      SEQ_MUL1:   state_nxt = SEQ_MUL2;
      SEQ_MUL2:   state_nxt = SEQ_MUL3;
      SEQ_MUL3:   state_nxt = SEQ_MUL4;
      SEQ_MUL4:   state_nxt = SEQ_MUL5;
      SEQ_MUL5:   state_nxt = SEQ_ASUM;
      SEQ_ASUM:   state_nxt = SEQ_SQRT;
      SEQ_SQRT:   if (sq_cnt_r == 5'(SQRT_STEPS-1)) state_nxt = SEQ_VLOAD;
      SEQ_VLOAD:  state_nxt = SEQ_VEC;
      SEQ_VEC:    if (cordic_rsp.done) state_nxt = SEQ_DMUL;
      SEQ_DMUL:   state_nxt = SEQ_DIST;
      SEQ_DIST:   state_nxt = SEQ_RESULT;
      SEQ_RESULT: if (!out_valid_r || out_tready) state_nxt = SEQ_IDLE;
      default:    state_nxt = SEQ_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop      = 1'b0;
    commit     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    cordic_req = '0;
    unique case (state_r)
      SEQ_IDLE:   q_pop = q_valid;
      SEQ_ANGLE: begin
        mul_a = signed'({8'b0, ang_mag});
        mul_b = DEG_TO_RAD;
      end
      SEQ_ZLOAD: begin
        cordic_req.start = 1'b1;
        cordic_req.x     = GAIN_INV;
        cordic_req.z     = z0;
      end
      SEQ_MUL1: begin
        mul_a = s_dlat_r;
        mul_b = s_dlat_r;
      end
      SEQ_MUL2: begin
        mul_a = c1_r;
        mul_b = c2_r;
      end
      SEQ_MUL3: begin
        mul_a = s_dlon_r;
        mul_b = s_dlon_r;
      end
      SEQ_MUL5: begin
        mul_a = cc_r;
        mul_b = sd_r;
      end
      SEQ_VLOAD: begin
        cordic_req.start = 1'b1;
        cordic_req.vec   = 1'b1;
        cordic_req.x     = signed'({3'b000, q_lane_r.root});
        cordic_req.y     = signed'({3'b000, p_lane_r.root});
      end
      SEQ_DMUL: begin
        mul_a = zc_r;
        mul_b = TWO_EARTH_KM;
      end
      SEQ_RESULT: commit = !out_valid_r || out_tready;
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
    unique case (state_r)
      SEQ_IDLE: begin
        item_r <= q_item;
        k_r    <= '0;
      end
      SEQ_ANGLE: begin
        flip_r <= ang_flip;
        neg_r  <= ang_f[26];
      end
      SEQ_ROT: begin
        if (cordic_rsp.done) begin
          unique case (k_r)
            2'd0:    s_dlat_r <= rot_sin;
            2'd1:    s_dlon_r <= rot_sin;
            2'd2:    c1_r     <= rot_cos;
            default: c2_r     <= rot_cos;
          endcase
          k_r <= k_r + 1'b1;
        end
      end
      SEQ_MUL2: t1_r <= 32'(prod_r >>> 30);
      SEQ_MUL3: cc_r <= 32'(prod_r >>> 30);
      SEQ_MUL4: sd_r <= 32'(prod_r >>> 30);
      SEQ_ASUM: begin
        p_lane_r <= '{v: {1'b0, a_c, 30'b0}, rem: '0, root: '0};
        q_lane_r <= '{v: {1'b0, 31'(ONE_Q30 - a_c), 30'b0}, rem: '0, root: '0};
        sq_cnt_r <= '0;
      end
      SEQ_SQRT: begin
        p_lane_r <= sq_step(p_lane_r);
        q_lane_r <= sq_step(q_lane_r);
        sq_cnt_r <= sq_cnt_r + 1'b1;
      end
      SEQ_VEC: begin
        if (cordic_rsp.done) begin
          zc_r <= cordic_rsp.z[CW-1] ? '0 : 32'(cordic_rsp.z);
        end
      end
      SEQ_DIST: dist_r <= (dwide > 42'(DIST_MAX)) ? DIST_MAX : 23'(dwide);
      default: begin
      end
    endcase
    if (commit) begin
      out_relay_r  <= active_nxt;
      out_dist_r   <= dist_out;
      out_status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      active_r    <= 1'b0;
      ticks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        active_r    <= active_nxt;
        ticks_r     <= ticks_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_dist_r, out_relay_r};
  assign out_tuser  = out_status_r;

endmodule

// ===== hw/rtl/geofence_distance_alarm.sv =====
// ----------------------------------------------------------------------------
// geofence_distance_alarm
// Siren relay controller with a haversine great-circle geofence.
// ----------------------------------------------------------------------------
// Every input transfer gives exactly one output transfer, in order. Tick,
// alarm off, reset and alarm on with an unset home go straight from idle to
// the result state in the execution side. An alarm on with a home set runs
// four sine/cosine passes and one arctangent pass through the single shared
// CORDIC unit, plus a 31-step square root.
// A four-entry queue lets items be taken while a distance is being worked out,
// and the output register lets the next item start while a result waits.
module geofence_distance_alarm #(
  parameter int CORDIC_ITERATIONS = gda_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // quake_latitude[23:0], quake_longitude[48:24],
                                  // danger_radius[71:49]
  input  logic [1:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // relay_on[0], distance[23:1]
  output logic [2:0]  out_tuser,  // status
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [24:0] cfg_wdata
);
  import gda_pkg::*;

  logic signed [23:0] home_lat_r;
  logic signed [24:0] home_lon_r;
  logic [15:0]        duration_r;
  logic               q_valid, q_pop;
  item_t              q_item;
  cordic_req_t        cordic_req;
  cordic_rsp_t        cordic_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_lat_r <= '0;
      home_lon_r <= '0;
      duration_r <= DURATION_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_HOME_LAT: home_lat_r <= signed'(cfg_wdata[23:0]);
        REG_HOME_LON: home_lon_r <= signed'(cfg_wdata);
        REG_DURATION: duration_r <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  gda_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .home_lat  (home_lat_r),
    .home_lon  (home_lon_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  gda_cordic #(
    .ITERATIONS (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cordic_req),
    .rsp   (cordic_rsp)
  );

  gda_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .home_lat   (home_lat_r),
    .home_lon   (home_lon_r),
    .duration   (duration_r),
    .cordic_req (cordic_req),
    .cordic_rsp (cordic_rsp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // a distance only comes with a geofence verdict
  a_dist_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[23:1] != '0) |->
      (out_tuser == ST_STARTED || out_tuser == ST_OUTSIDE))
    else $error("distance without geofence status");

  a_started_relay: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_STARTED) |-> out_tdata[0])
    else $error("alarm started but relay off");

  a_release_relay: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_OFF || out_tuser == ST_TIMEOUT)) |-> !out_tdata[0])
    else $error("relay still on after release");

  a_dist_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:1] <= DIST_MAX))
    else $error("distance above saturation");

endmodule

// ===== tb/sv/geofence_distance_alarm_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// geofence_distance_alarm_test
// Drives command and tick transfers into the siren relay controller with
// random flow control on both sides, predicts relay level, great-circle
// distance and status in fixed point, and compares every result transfer.
// ----------------------------------------------------------------------------
module geofence_distance_alarm_test;
  import gda_pkg::*;

  localparam int ITER = CORDIC_ITERATIONS_DEF;
  localparam int LIMIT_CYCLES = 2_500_000;

  typedef struct {
    bit          relay;
    bit [22:0]   distance;
    status_t     st;
  } relay_result_t;

  class relay_scoreboard;
    logic signed [23:0] home_lat;
    logic signed [24:0] home_lon;
    logic [15:0]        duration;
    bit                 active;
    logic [15:0]        ticks;
    relay_result_t      pending_q[$];
    int                 errors;
    longint             atan_tab[32];

    function new();
      atan_tab = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
        64'h00000001, 64'h00000000};
      home_lat = '0;
      home_lon = '0;
      duration = DURATION_RST;
      active   = 0;
      ticks    = '0;
      errors   = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [24:0] val);
      case (idx)
        REG_HOME_LAT: home_lat = val[23:0];
        REG_HOME_LON: home_lon = val[24:0];
        REG_DURATION: duration = val[15:0];
        default: ;
      endcase
    endfunction

    // angle t in 2^-17 degree units
    function void sine_cosine(longint t, output longint s, output longint c);
      bit     flip;
      longint x, y, z, nx, mag;
      flip = 0;
      if (t > longint'(QUARTER_TURN)) begin
        t -= longint'(HALF_TURN);
        flip = 1;
      end else if (t < -longint'(QUARTER_TURN)) begin
        t += longint'(HALF_TURN);
        flip = 1;
      end
      mag = (t < 0) ? -t : t;
      z = (mag * 64'd74961321) >>> 19;
      if (t < 0) z = -z;
      x = longint'(GAIN_INV);
      y = 0;
      for (int i = 0; i < ITER && i < 32; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y  = y + (x >>> i);
          z -= atan_tab[i];
        end else begin
          nx = x + (y >>> i);
          y  = y - (x >>> i);
          z += atan_tab[i];
        end
        x = nx;
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
    endfunction

    function longint unsigned floor_root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint unsigned predict_distance(longint lat1, longint lon1,
                                               longint lat2, longint lon2);
      longint s_dlat, c_dlat, s_dlon, c_dlon, s1, c1, s2, c2;
      longint a, x, y, z, nx, cc;
      longint unsigned d;
      sine_cosine(lat2 - lat1, s_dlat, c_dlat);
      sine_cosine(lon2 - lon1, s_dlon, c_dlon);
      sine_cosine(lat1 * 2, s1, c1);
      sine_cosine(lat2 * 2, s2, c2);
      cc = (c1 * c2) >>> 30;
      a = ((s_dlat * s_dlat) >>> 30) + ((cc * ((s_dlon * s_dlon) >>> 30)) >>> 30);
      if (a < 0) a = 0;
      if (a > (64'sd1 <<< 30)) a = 64'sd1 <<< 30;
      y = longint'(floor_root(longint'(a) << 30));
      x = longint'(floor_root(longint'((64'sd1 <<< 30) - a) << 30));
      z = 0;
      for (int i = 0; i < ITER && i < 32; i++) begin
        if (y > 0) begin
          nx = x + (y >>> i);
          y  = y - (x >>> i);
          z += atan_tab[i];
        end else begin
          nx = x - (y >>> i);
          y  = y + (x >>> i);
          z -= atan_tab[i];
        end
        x = nx;
      end
      if (z < 0) z = 0;
      d = (longint'(2 * z) * 64'd6371 + (64'd1 << 21)) >> 22;
      return (d > DIST_MAX) ? DIST_MAX : d;
    endfunction

    function void note_item(opcode_t op, logic signed [23:0] lat,
                            logic signed [24:0] lon, logic [22:0] rad);
      relay_result_t   res;
      longint unsigned d;
      res.distance = '0;
      res.st       = ST_NONE;
      case (op)
        OP_TICK: begin
          if (ticks != 16'hFFFF) ticks++;
          if (active && ticks >= duration) begin
            active = 0;
            res.st = ST_TIMEOUT;
          end
        end
        OP_ALARM_ON: begin
          if (home_lat == 0 && home_lon == 0) begin
            res.st = ST_UNSET;
          end else begin
            d = predict_distance(longint'(home_lat), longint'(home_lon),
                                 longint'(lat), longint'(lon));
            res.distance = d[22:0];
            if (d <= rad) begin
              active = 1;
              ticks  = '0;
              res.st = ST_STARTED;
            end else begin
              res.st = ST_OUTSIDE;
            end
          end
        end
        OP_ALARM_OFF: begin
          active = 0;
          res.st = ST_OFF;
        end
        default: begin
          active = 0;
          ticks  = '0;
        end
      endcase
      res.relay = active;
      pending_q.push_back(res);
    endfunction

    function void check_result(logic [23:0] data, logic [2:0] user);
      relay_result_t e;
      if (pending_q.size() == 0) begin
        $error("result transfer with nothing expected: data %h status %0d", data, user);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (data[0] !== e.relay) begin
        $error("relay_on: expected %0d, got %0d", e.relay, data[0]);
        errors++;
      end
      if (data[23:1] !== e.distance) begin
        $error("distance: expected %0d, got %0d", e.distance, data[23:1]);
        errors++;
      end
      if (user !== e.st) begin
        $error("status: expected %0d, got %0d", e.st, user);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;   // quake_latitude, quake_longitude, danger_radius
  logic [1:0]  in_tuser = '0;   // opcode
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [23:0] out_tdata;       // relay_on, distance
  logic [2:0]  out_tuser;       // status
  logic        cfg_we = 0;
  logic [1:0]  cfg_addr = '0;
  logic [24:0] cfg_wdata = '0;

  relay_scoreboard sb = new();
  int  cycle_count = 0;
  int  burst_left  = 0;
  bit  no_gaps     = 0;
  bit  hold_request = 0;

  geofence_distance_alarm u_top (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_we, .cfg_addr, .cfg_wdata
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL geofence_distance_alarm");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);

  // receiver stall pattern, with one long hold-off on request
  int hold_cycles = 0;
  int mode_left = 0;
  int ready_mode = 0;
  always @(negedge clk) begin
    if (hold_request && hold_cycles == 0) begin
      hold_request <= 0;
      hold_cycles  <= 3000;
      out_tready   <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready  <= 0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(20, 300);
      end
      mode_left--;
      case (ready_mode)
        0: out_tready <= 1;
        1: out_tready <= $urandom_range(0, 1);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [24:0] val);
    @(negedge clk);
    cfg_we    <= 1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic send(opcode_t op, logic [23:0] lat, logic [24:0] lon, logic [22:0] rad);
    int gap;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 12);
        @(negedge clk);
        in_tvalid <= 0;
        repeat (gap - 1) @(negedge clk);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    @(negedge clk);
    in_tvalid <= 1;
    in_tuser  <= op;
    in_tdata  <= {rad, lon, lat};
    do @(posedge clk); while (!in_tready);
    sb.note_item(op, lat, lon, rad);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic random_home();
    case ($urandom_range(0, 3))
      0: begin
        write_reg(REG_HOME_LAT, 25'(-5898240));
        write_reg(REG_HOME_LON, 25'(11796480));
      end
      1: begin
        write_reg(REG_HOME_LAT, 25'(5898240));
        write_reg(REG_HOME_LON, 25'(-11796480));
      end
      default: begin
        write_reg(REG_HOME_LAT, 25'($urandom_range(0, 11796480)) - 25'd5898240);
        write_reg(REG_HOME_LON, 25'($urandom_range(0, 23592960)) - 25'd11796480);
      end
    endcase
  endtask

  task automatic random_item();
    int                 r;
    logic [23:0]        lat;
    logic [24:0]        lon;
    logic [22:0]        rad;
    r   = $urandom_range(0, 99);
    lat = 24'($urandom());
    lon = 25'($urandom());
    rad = 23'($urandom());
    if (r < 45) begin
      // epicentre near home so that both inside and outside outcomes occur
      lat = sb.home_lat + 24'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      lon = sb.home_lon + 25'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      rad = ($urandom_range(0, 3) == 0) ? 23'($urandom_range(0, 5123840))
                                        : 23'($urandom_range(0, 60000));
      send(OP_ALARM_ON, lat, lon, rad);
    end else if (r < 55) begin
      send(OP_ALARM_ON, lat, lon, rad);
    end else if (r < 85) begin
      send(OP_TICK, lat, lon, rad);
    end else if (r < 93) begin
      send(OP_ALARM_OFF, lat, lon, rad);
    end else begin
      send(OP_RESET, lat, lon, rad);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // home still unset
    send(OP_ALARM_ON, 24'd0, 25'd0, 23'h7FFFFF);
    send(OP_TICK, 24'hFFFFFF, 25'h1FFFFFF, 23'h7FFFFF);
    drain();
    // one home register zero is still a valid home
    write_reg(REG_HOME_LON, 25'd655360);
    write_reg(REG_DURATION, 25'd3);
    send(OP_ALARM_ON, 24'd0, 25'd655360, 23'd0);
    send(OP_ALARM_ON, 24'd0, 25'd655360, 23'd0);
    send(OP_TICK, 24'd0, 25'd0, 23'd0);
    send(OP_TICK, 24'd0, 25'd0, 23'd0);
    send(OP_TICK, 24'd0, 25'd0, 23'd0);
    send(OP_TICK, 24'd0, 25'd0, 23'd0);
    send(OP_ALARM_ON, 24'h7FFFFF, 25'h0FFFFFF, 23'h7FFFFF);
    send(OP_ALARM_ON, 24'h800000, 25'h1000000, 23'h7FFFFF);
    send(OP_ALARM_OFF, 24'd0, 25'd0, 23'd0);
    send(OP_ALARM_OFF, 24'd0, 25'd0, 23'd0);
    send(OP_ALARM_ON, 24'(5898240), 25'(11796480), 23'd5123840);
    send(OP_ALARM_ON, 24'(-5898240), 25'(-11796480), 23'd100);
    send(OP_RESET, 24'hFFFFFF, 25'h1FFFFFF, 23'h7FFFFF);
    drain();
    write_reg(REG_HOME_LAT, 25'(-5898240));
    write_reg(REG_HOME_LON, 25'(11796480));
    write_reg(REG_DURATION, 25'd0);
    send(OP_ALARM_ON, 24'(5898240), 25'(-11796480), 23'h7FFFFF);
    send(OP_ALARM_ON, 24'(-5898240), 25'(11796480), 23'd0);
    send(OP_TICK, 24'd0, 25'd0, 23'd0);
    send(OP_TICK, 24'd0, 25'd0, 23'd0);
    drain();

    // longest duration, relay held through a run of back to back ticks
    write_reg(REG_DURATION, 25'd65535);
    send(OP_ALARM_ON, 24'(-5898240), 25'(11796480), 23'h7FFFFF);
    no_gaps = 1;
    repeat (40) send(OP_TICK, 24'($urandom()), 25'($urandom()), 23'($urandom()));
    no_gaps = 0;
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      random_home();
      write_reg(REG_DURATION, (phase == 5) ? 25'd1 : 25'($urandom_range(1, 40)));
      no_gaps = (phase == 2);
      for (int n = 0; n < 100; n++) begin
        if (phase == 3 && n == 10) hold_request = 1;
        random_item();
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("PASS geofence_distance_alarm");
    else
      $display("FAIL geofence_distance_alarm");
    $finish;
  end

endmodule
